// File: rtl/core/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants and types of the LRU page replacement block: slot count,
// field widths, and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package lpr_pkg;

   // Built slot count and widths that follow from it
   localparam int SLOTS     = 16;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int CNT_BITS  = SLOT_BITS + 1;
   localparam int AGE_BITS  = SLOT_BITS;

   // Fixed field widths
   localparam int PAGE_BITS  = 16;
   localparam int ACT_BITS   = 5;
   localparam int TOTAL_BITS = 32;

   localparam logic [AGE_BITS-1:0]   AGE_MAX   = AGE_BITS'(SLOTS - 1);
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   // Command bundle: controller to datapath
   typedef struct packed {
      logic                 load;       // capture a new reference
      logic                 scan;       // examine slot at idx
      logic                 first;      // idx is slot zero
      logic [SLOT_BITS-1:0] idx;        // slot under examination
      logic                 update;     // apply replacement and aging
      logic [CNT_BITS-1:0]  active_cnt; // slots in use, 1..SLOTS
   } cmd_type;

endpackage

// File: rtl/core/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// lpr_ctrl
// Controller of the LRU page replacement block: holds the active-entries
// register, walks the slot index across the active slots, and sequences the
// load, scan and update steps of the datapath.
// ----------------------------------------------------------------------------
module lpr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lpr_pkg::ACT_BITS-1:0]  csr_active_entries,
   output lpr_pkg::cmd_type              cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [lpr_pkg::SLOT_BITS-1:0]      idx_ff, idx_in;
   logic [lpr_pkg::ACT_BITS-1:0]       active_ff;
   logic [lpr_pkg::CNT_BITS-1:0]       active_cnt;
   logic [lpr_pkg::SLOT_BITS-1:0]      last_idx;

   // Configuration register
   assign csr_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= lpr_pkg::ACT_BITS'(lpr_pkg::SLOTS);
      end else if (csr_valid && csr_ready) begin
         active_ff <= csr_active_entries;
      end
   end

   // Clamp the active count into 1..SLOTS
   always_comb begin
      if (active_ff == '0) begin
         active_cnt = lpr_pkg::CNT_BITS'(1);
      end else if (active_ff > lpr_pkg::ACT_BITS'(lpr_pkg::SLOTS)) begin
         active_cnt = lpr_pkg::CNT_BITS'(lpr_pkg::SLOTS);
      end else begin
         active_cnt = lpr_pkg::CNT_BITS'(active_ff);
      end
   end

   assign last_idx = lpr_pkg::SLOT_BITS'(active_cnt - lpr_pkg::CNT_BITS'(1));

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      cmd.idx    = idx_ff;
      cmd.first  = (idx_ff == '0);
      cmd.active_cnt = active_cnt;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (idx_ff == last_idx) begin
               state_in = ST_UPDATE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // The scan never runs past the last active slot
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (lpr_pkg::CNT_BITS'(idx_ff) < active_cnt))
      else $error("scan index beyond active slots");

   // Every update follows a scan
   a_update_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ($past(state_ff) == ST_SCAN))
      else $error("update without scan");

endmodule

// File: rtl/core/lpr_datapath.sv
// ----------------------------------------------------------------------------
// lpr_datapath
// Datapath of the LRU page replacement block: slot pages, valid bits and
// ages, the per-reference search trackers, the saturating counters and the
// result registers.
// ----------------------------------------------------------------------------
module lpr_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  lpr_pkg::cmd_type                 cmd,
   input  logic [lpr_pkg::PAGE_BITS-1:0]    req_page_number,
   output logic                             rsp_strobe,
   output logic                             rsp_hit,
   output logic [lpr_pkg::SLOT_BITS-1:0]    rsp_slot,
   output logic                             rsp_evicted_valid,
   output logic [lpr_pkg::PAGE_BITS-1:0]    rsp_evicted_page,
   output logic [lpr_pkg::TOTAL_BITS-1:0]   rsp_fault_total,
   output logic [lpr_pkg::TOTAL_BITS-1:0]   rsp_request_total
);

   // Slot state
   logic [lpr_pkg::PAGE_BITS-1:0] slot_page_ff [lpr_pkg::SLOTS];
   logic [lpr_pkg::SLOTS-1:0]     slot_valid_ff;
   logic [lpr_pkg::AGE_BITS-1:0]  slot_age_ff  [lpr_pkg::SLOTS];

   // Reference trackers
   logic [lpr_pkg::PAGE_BITS-1:0] page_ff;
   logic                          hit_found_ff;
   logic [lpr_pkg::SLOT_BITS-1:0] hit_idx_ff;
   logic [lpr_pkg::AGE_BITS-1:0]  hit_age_ff;
   logic                          empty_found_ff;
   logic [lpr_pkg::SLOT_BITS-1:0] empty_idx_ff;
   logic [lpr_pkg::AGE_BITS-1:0]  old_age_ff;
   logic [lpr_pkg::SLOT_BITS-1:0] old_idx_ff;
   logic [lpr_pkg::PAGE_BITS-1:0] old_page_ff;

   logic [lpr_pkg::TOTAL_BITS-1:0] fault_ff, fault_in;
   logic [lpr_pkg::TOTAL_BITS-1:0] request_ff, request_in;

   logic [lpr_pkg::PAGE_BITS-1:0] rd_page;
   logic                          rd_valid;
   logic [lpr_pkg::AGE_BITS-1:0]  rd_age;
   logic                          rd_match;
   logic [lpr_pkg::SLOT_BITS-1:0] target;
   logic                          evict;

   // Read the slot under examination
   assign rd_page  = slot_page_ff[cmd.idx];
   assign rd_valid = slot_valid_ff[cmd.idx];
   assign rd_age   = slot_age_ff[cmd.idx];
   assign rd_match = rd_valid && (rd_page == page_ff);

   // Track first match, first empty slot and oldest slot during the scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff        <= req_page_number;
         hit_found_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (rd_match && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= cmd.idx;
            hit_age_ff   <= rd_age;
         end
         if (!rd_valid && !empty_found_ff) begin
            empty_found_ff <= 1'b1;
            empty_idx_ff   <= cmd.idx;
         end
         if (cmd.first || (rd_age > old_age_ff)) begin
            old_age_ff  <= rd_age;
            old_idx_ff  <= cmd.idx;
            old_page_ff <= rd_page;
         end
      end
   end

   // Pick the slot that ends up holding the page
   always_comb begin
      if (hit_found_ff) begin
         target = hit_idx_ff;
      end else if (empty_found_ff) begin
         target = empty_idx_ff;
      end else begin
         target = old_idx_ff;
      end
   end

   assign evict = !hit_found_ff && !empty_found_ff;

   // Age the other valid active slots (on a hit, only those younger than it) and refresh the target
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         for (int i = 0; i < lpr_pkg::SLOTS; i++) begin
            slot_age_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         for (int i = 0; i < lpr_pkg::SLOTS; i++) begin
            if (lpr_pkg::SLOT_BITS'(i) == target) begin
               slot_age_ff[i] <= '0;
               if (!hit_found_ff) begin
                  slot_valid_ff[i] <= 1'b1;
               end
            end else if ((lpr_pkg::CNT_BITS'(i) < cmd.active_cnt) && slot_valid_ff[i] &&
                         (!hit_found_ff || (slot_age_ff[i] < hit_age_ff)) &&
                         (slot_age_ff[i] != lpr_pkg::AGE_MAX)) begin
               slot_age_ff[i] <= slot_age_ff[i] + 1'b1;
            end
         end
      end
   end

   // Store the new page on a fault
   always_ff @(posedge clock) begin
      if (cmd.update && !hit_found_ff) begin
         slot_page_ff[target] <= page_ff;
      end
   end

   // Saturating counters
   always_comb begin
      request_in = request_ff;
      fault_in   = fault_ff;
      if (request_ff != lpr_pkg::TOTAL_MAX) begin
         request_in = request_ff + 1'b1;
      end
      if (!hit_found_ff && (fault_ff != lpr_pkg::TOTAL_MAX)) begin
         fault_in = fault_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         request_ff <= '0;
         fault_ff   <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.update;
         if (cmd.update) begin
            request_ff <= request_in;
            fault_ff   <= fault_in;
         end
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit           <= hit_found_ff;
         rsp_slot          <= target;
         rsp_evicted_valid <= evict;
         rsp_evicted_page  <= evict ? old_page_ff : '0;
         rsp_fault_total   <= fault_in;
         rsp_request_total <= request_in;
      end
   end

   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_strobe)
      else $error("missing result strobe after update");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> !rsp_evicted_valid)
      else $error("eviction reported on a hit");

   a_fault_le_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_fault_total <= rsp_request_total))
      else $error("fault count exceeds request count");

   a_target_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> slot_valid_ff[rsp_slot])
      else $error("result slot not valid after update");

endmodule

// File: rtl/core/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page table with saturating fault and request counts.
// ----------------------------------------------------------------------------
// A reference is taken when start is high and busy is low. The block then
// examines one slot per cycle across the active slots, applies the update,
// and shows the result on the rsp_ ports for exactly one cycle with
// rsp_strobe high; the receiver cannot stall it. busy falls in the strobe
// cycle, so the next reference can be taken then. active_entries is written
// through csr_ when csr_ready is high (idle); zero counts as one slot and
// values above the slot count as the slot count.
// ----------------------------------------------------------------------------
module lru_page_replacement (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [lpr_pkg::PAGE_BITS-1:0]    req_page_number,
   output logic                             rsp_strobe,
   output logic                             rsp_hit,
   output logic [lpr_pkg::SLOT_BITS-1:0]    rsp_slot,
   output logic                             rsp_evicted_valid,
   output logic [lpr_pkg::PAGE_BITS-1:0]    rsp_evicted_page,
   output logic [lpr_pkg::TOTAL_BITS-1:0]   rsp_fault_total,
   output logic [lpr_pkg::TOTAL_BITS-1:0]   rsp_request_total,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lpr_pkg::ACT_BITS-1:0]     csr_active_entries
);

   lpr_pkg::cmd_type cmd;

   // Sequencer
   lpr_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_active_entries (csr_active_entries),
      .cmd                (cmd)
   );

   // Slot table, counters and results
   lpr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_page_number   (req_page_number),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .rsp_request_total (rsp_request_total)
   );

endmodule
